/* rtl/frnq_pkg.sv */
// shared constants, types and helpers of the fixed-radius neighbor query block
`default_nettype none
package frnq_pkg;

	localparam int NODES      = 64;
	localparam int COORD_BITS = 16;

	localparam int IDX_W     = 6;
	localparam int CELL_W    = 8;
	localparam int FIELD_W   = 16;
	localparam int CUT_W     = 34;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int ADDR_W    = $clog2(NODES);

	localparam int MAG_W  = COORD_BITS + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int CMP_W  = (SUM_W > CUT_W) ? SUM_W : CUT_W;

	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [CELL_W-1:0] owner;
		coord_t            x;
		coord_t            y;
		coord_t            z;
	} node_t;

	typedef struct packed {
		logic       en;
		logic       first;
		logic [1:0] axis;
	} dist_ctrl_t;

	function automatic coord_t coord_from_field(input logic [FIELD_W-1:0] v);
		logic signed [31:0] ext;
		ext = 32'(signed'(v));
		return ext[COORD_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/frnq_node_mem.sv */
// node table memory, one write port and one registered read port
`default_nettype none
module frnq_node_mem
	import frnq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire node_t             wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output node_t                  rd_data
);

	node_t mem [NODES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/frnq_dist_unit.sv */
// shared squared-distance unit, one axis per cycle while ctrl.en is set, with accumulator
`default_nettype none
module frnq_dist_unit
	import frnq_pkg::*;
(
	input  wire logic             clk,
	input  wire dist_ctrl_t       ctrl,
	input  wire coord_t           q_x,
	input  wire coord_t           q_y,
	input  wire coord_t           q_z,
	input  wire coord_t           e_x,
	input  wire coord_t           e_y,
	input  wire coord_t           e_z,
	output logic [SUM_W-1:0]      dist_sum
);

	coord_t             a;
	coord_t             b;
	logic [MAG_W-1:0]   diff;
	logic [MAG_W-1:0]   mag;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   acc_q;

	always_comb begin
		case (ctrl.axis)
			AXIS_X: begin
				a = q_x;
				b = e_x;
			end
			AXIS_Y: begin
				a = q_y;
				b = e_y;
			end
			AXIS_Z: begin
				a = q_z;
				b = e_z;
			end
			default: begin
				a = q_x;
				b = e_x;
			end
		endcase
		diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_q <= mag * mag;
			acc_q  <= ctrl.first ? '0 : (acc_q + SUM_W'(prod_q));
		end
	end

	assign dist_sum = acc_q + SUM_W'(prod_q);

endmodule
`default_nettype wire

/* rtl/fixed_radius_neighbor_query.sv */
// top level: node table, query sequencer and result register
//
// channel  dir  handshake            payload
// in       in   in_valid / in_ready  op, index, cell_id, pos_x, pos_y, pos_z
// out      out  out_valid / out_ready neighbor_index, found, last
// cfg      in   cfg_we               cfg_index, cfg_wdata
//
// a write is stored on its transfer; a query loads the queried entry, then scans each active entry
// through AX0, AX1, AX2 and CMP, set by the single multiplier that squares one axis a cycle
// in_ready is low from a query transfer until its last result is in the output register
// a full output register stalls the scan at the next match
// reset clears control and configuration; the node table holds no reset value
`default_nettype none
module fixed_radius_neighbor_query
	import frnq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CUT_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 op,
	input  wire logic [IDX_W-1:0]     index,
	input  wire logic [CELL_W-1:0]    cell_id,
	input  wire logic [FIELD_W-1:0]   pos_x,
	input  wire logic [FIELD_W-1:0]   pos_y,
	input  wire logic [FIELD_W-1:0]   pos_z,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [IDX_W-1:0]          neighbor_index,
	output logic                      found,
	output logic                      last
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_QLOAD  = 3'd1;
	localparam logic [2:0] S_AX0    = 3'd2;
	localparam logic [2:0] S_AX1    = 3'd3;
	localparam logic [2:0] S_AX2    = 3'd4;
	localparam logic [2:0] S_CMP    = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [CUT_W-1:0]  cutoff_sq_q;
	logic [CNT_W-1:0]  node_count_q;
	logic [CNT_W-1:0]  active;
	logic [ADDR_W-1:0] k_q;
	logic              pend_valid_q;
	logic [ADDR_W-1:0] pend_idx_q;
	logic [CELL_W-1:0] q_cell_q;
	coord_t            q_x_q;
	coord_t            q_y_q;
	coord_t            q_z_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_found_q;
	logic              out_last_q;

	logic              in_xfer;
	logic              idx_ok;
	logic              out_free;
	logic              mem_we;
	node_t             wr_node;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	node_t             rd_data;
	dist_ctrl_t        dctrl;
	logic [SUM_W-1:0]  dist_sum;
	logic              match;
	logic              k_end;
	logic              cmp_go;
	logic              emit;
	logic [IDX_W-1:0]  emit_idx;
	logic              emit_found;
	logic              emit_last;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign idx_ok   = (CNT_W'(index) < CNT_W'(NODES));
	assign out_free = !out_valid_q || out_ready;
	assign active   = (node_count_q > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_q;
	assign k_end    = ((CNT_W'(k_q) + 1'b1) == active);

	assign mem_we  = in_xfer && (op == OP_WRITE) && idx_ok;
	assign wr_node = '{owner: cell_id, x: coord_from_field(pos_x),
		y: coord_from_field(pos_y), z: coord_from_field(pos_z)};

	frnq_node_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (index[ADDR_W-1:0]),
		.wr_data (wr_node),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		dctrl = '{en: 1'b0, first: 1'b0, axis: AXIS_X};
		case (state_q)
			S_AX0:   dctrl = '{en: 1'b1, first: 1'b1, axis: AXIS_X};
			S_AX1:   dctrl = '{en: 1'b1, first: 1'b0, axis: AXIS_Y};
			S_AX2:   dctrl = '{en: 1'b1, first: 1'b0, axis: AXIS_Z};
			default: dctrl = '{en: 1'b0, first: 1'b0, axis: AXIS_X};
		endcase
	end

	frnq_dist_unit u_dist (
		.clk      (clk),
		.ctrl     (dctrl),
		.q_x      (q_x_q),
		.q_y      (q_y_q),
		.q_z      (q_z_q),
		.e_x      (rd_data.x),
		.e_y      (rd_data.y),
		.e_z      (rd_data.z),
		.dist_sum (dist_sum)
	);

	assign match  = (rd_data.owner != q_cell_q) && (CMP_W'(dist_sum) < CMP_W'(cutoff_sq_q));
	assign cmp_go = !(match && pend_valid_q) || out_free;

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = k_q;
		emit       = 1'b0;
		emit_idx   = IDX_W'(pend_idx_q);
		emit_found = 1'b1;
		emit_last  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && (op == OP_QUERY)) begin
					if (idx_ok) begin
						rd_en   = 1'b1;
						rd_addr = index[ADDR_W-1:0];
						state_d = S_QLOAD;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_QLOAD: begin
				if (active == '0) begin
					state_d = S_FINISH;
				end else begin
					rd_en   = 1'b1;
					rd_addr = '0;
					state_d = S_AX0;
				end
			end
			S_AX0: state_d = S_AX1;
			S_AX1: state_d = S_AX2;
			S_AX2: state_d = S_CMP;
			S_CMP: begin
				if (cmp_go) begin
					emit = match && pend_valid_q;
					if (k_end) begin
						state_d = S_FINISH;
					end else begin
						rd_en   = 1'b1;
						rd_addr = k_q + 1'b1;
						state_d = S_AX0;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_idx   = pend_valid_q ? IDX_W'(pend_idx_q) : '0;
					emit_found = pend_valid_q;
					emit_last  = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cutoff_sq_q  <= '0;
			node_count_q <= '0;
			k_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_CUTOFF_SQ:  cutoff_sq_q  <= cfg_wdata;
					REG_NODE_COUNT: node_count_q <= cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_QLOAD) begin
				k_q          <= '0;
				pend_valid_q <= 1'b0;
			end else if ((state_q == S_CMP) && cmp_go) begin
				k_q <= k_q + 1'b1;
				if (match) begin
					pend_valid_q <= 1'b1;
				end
			end else if ((state_q == S_FINISH) && out_free) begin
				pend_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_QLOAD) begin
			q_cell_q <= rd_data.owner;
			q_x_q    <= rd_data.x;
			q_y_q    <= rd_data.y;
			q_z_q    <= rd_data.z;
		end
		if ((state_q == S_CMP) && cmp_go && match) begin
			pend_idx_q <= k_q;
		end
		if (emit) begin
			out_idx_q   <= emit_idx;
			out_found_q <= emit_found;
			out_last_q  <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign neighbor_index = out_idx_q;
	assign found          = out_found_q;
	assign last           = out_last_q;

`ifndef SYNTHESIS
	a_nomatch_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> last)
		else $error("no-match result without last");

	a_query_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (op == OP_QUERY)) |=> !in_ready)
		else $error("input taken while a query is in progress");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending match left over after query");
`endif

endmodule
`default_nettype wire

/* sim/testbench.sv */
// testbench of the fixed-radius neighbor query block: directed table, random phases, own predictor
`timescale 1ns / 1ps
module testbench
	import frnq_pkg::*;
;

	typedef struct packed {
		logic                 op;
		logic [IDX_W-1:0]     idx;
		logic [CELL_W-1:0]    owner;
		logic [FIELD_W-1:0]   x;
		logic [FIELD_W-1:0]   y;
		logic [FIELD_W-1:0]   z;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] nidx;
		logic             found;
		logic             last;
	} hit_t;

	typedef struct packed {
		logic              set_cfg;
		logic [CUT_W-1:0]  cut;
		logic [CNT_W-1:0]  cnt;
		item_t             it;
		logic              typed;
		hit_t              hit;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CUT_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic                 op;
	logic [IDX_W-1:0]     index;
	logic [CELL_W-1:0]    cell_id;
	logic [FIELD_W-1:0]   pos_x;
	logic [FIELD_W-1:0]   pos_y;
	logic [FIELD_W-1:0]   pos_z;
	logic                 out_valid;
	logic                 out_ready;
	logic [IDX_W-1:0]     neighbor_index;
	logic                 found;
	logic                 last;

	fixed_radius_neighbor_query u_top (.*);

	logic [CUT_W-1:0]              cutoff_now;
	logic [CNT_W-1:0]              count_now;
	logic [CELL_W-1:0]             node_cell [NODES];
	logic signed [COORD_BITS-1:0]  node_pos [NODES][3];

	hit_t pending_hits[$];
	row_t plan[15];
	int   errors;
	int   tx_idle;
	int   rx_idle;
	bit   hold_go;
	int   hold_left;

	always #5 clk = ~clk;

	function automatic logic signed [COORD_BITS-1:0] stored_coord(logic [FIELD_W-1:0] v);
		logic [31:0] wide;
		wide = {{(32 - FIELD_W){v[FIELD_W-1]}}, v};
		return wide[COORD_BITS-1:0];
	endfunction

	// updates the table on a write, queues the neighbor hits of a query
	function automatic void predict_hits(item_t it);
		int                active;
		logic [CELL_W-1:0] qcell;
		logic [63:0]       d2;
		longint            d;
		bit                have;
		hit_t              prev;
		if (it.op == OP_WRITE) begin
			node_cell[it.idx]   = it.owner;
			node_pos[it.idx][0] = stored_coord(it.x);
			node_pos[it.idx][1] = stored_coord(it.y);
			node_pos[it.idx][2] = stored_coord(it.z);
			return;
		end
		active = (count_now > NODES) ? NODES : int'(count_now);
		qcell = node_cell[it.idx];
		have = 0;
		prev = '0;
		for (int k = 0; k < active; k++) begin
			if (node_cell[k] != qcell) begin
				d2 = 0;
				for (int a = 0; a < 3; a++) begin
					d = longint'(node_pos[it.idx][a]) - longint'(node_pos[k][a]);
					d2 += 64'(d * d);
				end
				if (d2 < 64'(cutoff_now)) begin
					if (have)
						pending_hits.push_back(prev);
					prev = '{IDX_W'(k), 1'b1, 1'b0};
					have = 1;
				end
			end
		end
		if (have) begin
			prev.last = 1'b1;
			pending_hits.push_back(prev);
		end else
			pending_hits.push_back('{'0, 1'b0, 1'b1});
	endfunction

	function automatic row_t mk_row(logic set_cfg, logic [CUT_W-1:0] cut, logic [CNT_W-1:0] cnt,
		logic o, logic [IDX_W-1:0] i, logic [CELL_W-1:0] c,
		logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic [FIELD_W-1:0] z,
		logic typed, logic f, logic [IDX_W-1:0] n);
		row_t r;
		r.set_cfg = set_cfg;
		r.cut     = cut;
		r.cnt     = cnt;
		r.it      = '{o, i, c, x, y, z};
		r.typed   = typed;
		r.hit     = '{n, f, 1'b1};
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] rand_coord();
		if ($urandom_range(0, 4) == 0)
			return FIELD_W'($urandom);
		return FIELD_W'($urandom_range(0, 1023)) - FIELD_W'(512);
	endfunction

	function automatic item_t rand_item(int query_pct);
		item_t it;
		it.op    = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_WRITE;
		it.idx   = IDX_W'($urandom);
		it.owner = ($urandom_range(0, 3) == 0) ? CELL_W'($urandom) : CELL_W'($urandom_range(0, 3));
		it.x     = rand_coord();
		it.y     = rand_coord();
		it.z     = rand_coord();
		return it;
	endfunction

	task automatic note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [CUT_W-1:0] v);
		cfg_we    = 1'b1;
		cfg_index = r;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		if (r == REG_CUTOFF_SQ)
			cutoff_now = v;
		else
			count_now = v[CNT_W-1:0];
	endtask

	task automatic settle();
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_config(logic [CUT_W-1:0] cut, logic [CNT_W-1:0] cnt);
		settle();
		write_reg(REG_CUTOFF_SQ, cut);
		write_reg(REG_NODE_COUNT, CUT_W'(cnt));
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send(item_t it, bit predict);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid = 1'b0;
			op       = 1'($urandom);
			index    = IDX_W'($urandom);
			cell_id  = CELL_W'($urandom);
			pos_x    = FIELD_W'($urandom);
			pos_y    = FIELD_W'($urandom);
			pos_z    = FIELD_W'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		op       = it.op;
		index    = it.idx;
		cell_id  = it.owner;
		pos_x    = it.x;
		pos_y    = it.y;
		pos_z    = it.z;
		do
			@(posedge clk);
		while (!in_ready);
		if (predict)
			predict_hits(it);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = 400;
			hold_go = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else
			out_ready = ($urandom_range(0, 99) >= rx_idle);
	end

	always @(posedge clk) begin
		hit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_hits.size() == 0)
				note_error($sformatf("unexpected result idx %0d found %0b last %0b",
					neighbor_index, found, last));
			else begin
				want = pending_hits.pop_front();
				if (want.nidx !== neighbor_index || want.found !== found || want.last !== last)
					note_error($sformatf(
						"mismatch: expected idx %0d found %0b last %0b, got idx %0d found %0b last %0b",
						want.nidx, want.found, want.last, neighbor_index, found, last));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		item_t              it;
		logic [CUT_W-1:0]   cut;
		logic [CNT_W-1:0]   cnt;
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_CUTOFF_SQ;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		op         = OP_WRITE;
		index      = '0;
		cell_id    = '0;
		pos_x      = '0;
		pos_y      = '0;
		pos_z      = '0;
		out_ready  = 1'b0;
		errors     = 0;
		tx_idle    = 7;
		rx_idle    = 73;
		hold_go    = 0;
		hold_left  = 0;
		cutoff_now = '0;
		count_now  = '0;

		// query at reset config, coordinate extremes, cutoff boundaries, same cell,
		// queried entry beyond the active range, top index and cell id
		plan[0]  = mk_row(0, 0, 0, OP_WRITE, 0, 8'h01, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
		plan[1]  = mk_row(0, 0, 0, OP_QUERY, 0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
		plan[2]  = mk_row(0, 0, 0, OP_WRITE, 1, 8'h02, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0);
		plan[3]  = mk_row(0, 0, 0, OP_WRITE, 2, 8'h01, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
		plan[4]  = mk_row(0, 0, 0, OP_WRITE, 3, 8'h03, 16'h0001, 16'h0000, 16'h0000, 0, 0, 0);
		plan[5]  = mk_row(1, '1, 4, OP_QUERY, 0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
		plan[6]  = mk_row(0, 0, 0, OP_QUERY, 1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);
		plan[7]  = mk_row(1, 0, 4, OP_QUERY, 0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
		plan[8]  = mk_row(1, 1, 4, OP_QUERY, 0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0);
		plan[9]  = mk_row(1, 2, 4, OP_QUERY, 0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1, 1, 3);
		plan[10] = mk_row(1, 2, 2, OP_QUERY, 3, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0);
		plan[11] = mk_row(0, 0, 0, OP_WRITE, 3, 8'h01, 16'h0001, 16'h0000, 16'h0000, 0, 0, 0);
		plan[12] = mk_row(1, '1, 4, OP_QUERY, 3, 8'h00, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
		plan[13] = mk_row(0, 0, 0, OP_WRITE, 63, 8'hFF, 16'hFFFF, 16'h5555, 16'hAAAA, 0, 0, 0);
		plan[14] = mk_row(0, 0, 0, OP_QUERY, 63, 8'h00, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].set_cfg)
				set_config(plan[i].cut, plan[i].cnt);
			if (plan[i].typed) begin
				pending_hits.push_back(plan[i].hit);
				send(plan[i].it, 0);
			end else
				send(plan[i].it, 1);
		end

		// load every entry so that any query and any count reads written entries only
		for (int i = 0; i < NODES; i++) begin
			it = rand_item(0);
			it.idx = IDX_W'(i);
			send(it, 1);
		end

		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin tx_idle = 7;  rx_idle = 73; end
				1: begin tx_idle = 73; rx_idle = 7;  end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			case (p)
				0: begin cut = CUT_W'(3 << 19); cnt = 16; end
				1: begin
					cut = {2'($urandom_range(0, 3)), 32'($urandom)};
					cnt = CNT_W'($urandom_range(65, 127));
				end
				2: begin
					cut = CUT_W'($urandom_range(1 << 16, 1 << 20));
					cnt = CNT_W'($urandom_range(0, 63));
				end
				3: begin cut = '1; cnt = 1; end
				4: begin cut = '1; cnt = 64; end
				default: begin
					cut = CUT_W'(3 << 19);
					cnt = CNT_W'($urandom_range(2, 32));
				end
			endcase
			set_config(cut, cnt);
			if (p == 4)
				hold_go = 1;
			for (int j = 0; j < 20; j++) begin
				if (p == 5 && j == 10)
					settle();
				send(rand_item(70), 1);
			end
		end

		in_valid = 1'b0;
		settle();
		repeat (20) @(negedge clk);
		if (errors == 0 && pending_hits.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

/* files.f */
rtl/frnq_pkg.sv
rtl/frnq_node_mem.sv
rtl/frnq_dist_unit.sv
rtl/fixed_radius_neighbor_query.sv
sim/testbench.sv
